// ----- rtl/core/coefficient_rounding_hint_unit_assert.svh -----
// assertion macros for the coefficient rounding hint unit
// expects clk and arst_n in the scope of each use
`ifndef COEFFICIENT_ROUNDING_HINT_UNIT_ASSERT_SVH
`define COEFFICIENT_ROUNDING_HINT_UNIT_ASSERT_SVH

// same-cycle implication
`define CRHU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crhu assertion failed");

// implication after a fixed number of cycles
`define CRHU_ASSERT_DLY(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("crhu delayed assertion failed");

`endif

// ----- rtl/core/crhu_pkg.sv -----
// shared types and constants of the coefficient rounding hint unit
// no dependencies
package crhu_pkg;

	localparam int MOD_Q      = 8380417;
	localparam int HALF_Q     = (MOD_Q - 1) / 2;
	localparam int GAMMA2_88  = (MOD_Q - 1) / 88;
	localparam int GAMMA2_32  = (MOD_Q - 1) / 32;
	localparam int EXP_D      = 13;
	localparam int P2R_BIAS   = (1 << (EXP_D - 1)) - 1;
	localparam int PRE_BIAS   = 127;
	localparam int MUL_88     = 11275;
	localparam int MUL_32     = 1025;
	localparam int RND_88     = 1 << 23;
	localparam int RND_32     = 1 << 21;
	localparam int HI_MAX_88  = 43;

	localparam int COEFF_W = 24;
	localparam int LOW_W   = 19;
	localparam int HIGH_W  = 10;
	localparam int R0_W    = 27;
	localparam int R1_W    = 8;

	typedef enum logic [1:0] {
		OP_POWER2ROUND = 2'd0,
		OP_DECOMPOSE   = 2'd1,
		OP_MAKE_HINT   = 2'd2,
		OP_USE_HINT    = 2'd3
	} op_t;

	// request into the decompose pipeline
	typedef struct packed {
		logic                      mode;
		logic signed [COEFF_W-1:0] coeff;
	} split_in_t;

	// decompose result, four stages later
	typedef struct packed {
		logic signed [R0_W-1:0] r0;
		logic signed [R1_W-1:0] r1;
	} split_out_t;

endpackage

// ----- rtl/core/crhu_split.sv -----
// four-stage decompose datapath: coefficient to (r0, r1) for either gamma2
// depends on crhu_pkg
module crhu_split (
	input  logic                  clk,
	input  crhu_pkg::split_in_t   req,
	output crhu_pkg::split_out_t  rsp
);

	logic signed [crhu_pkg::COEFF_W:0]   sum7;
	logic signed [17:0]                  h1_s1;
	logic signed [crhu_pkg::COEFF_W-1:0] a_s1, a_s2, a_s3;
	logic                                mode_s1, mode_s2;

	logic signed [14:0] mul_k;
	logic signed [31:0] rnd_k;
	logic signed [31:0] prod_d, prod_s2;

	logic signed [7:0]  hsh;
	logic signed [7:0]  h_d, h_s3;
	logic signed [20:0] two_g;
	logic signed [25:0] hg_d, hg_s3;

	logic signed [crhu_pkg::R0_W-1:0] diff, r0_d, r0_s4;
	logic signed [crhu_pkg::R1_W-1:0] r1_s4;

	// stage 1: pre-shift by 7 with rounding bias
	assign sum7 = (crhu_pkg::COEFF_W + 1)'($signed(req.coeff))
		+ (crhu_pkg::COEFF_W + 1)'(crhu_pkg::PRE_BIAS);

	// stage 2: reciprocal multiply
	assign mul_k = mode_s1 ? 15'(crhu_pkg::MUL_32) : 15'(crhu_pkg::MUL_88);
	assign rnd_k = mode_s1 ? 32'(crhu_pkg::RND_32) : 32'(crhu_pkg::RND_88);
	assign prod_d = h1_s1 * mul_k + rnd_k;

	// stage 3: high index, fold and times 2*gamma2
	assign hsh   = prod_s2[31:24];
	assign h_d   = mode_s2 ? {4'b0000, prod_s2[25:22]} :
		((hsh > 8'(crhu_pkg::HI_MAX_88)) ? 8'sd0 : hsh);
	assign two_g = mode_s2 ? 21'(2 * crhu_pkg::GAMMA2_32) : 21'(2 * crhu_pkg::GAMMA2_88);
	assign hg_d  = h_d * two_g;

	// stage 4: low part with the wrap into the negative half
	assign diff = crhu_pkg::R0_W'(a_s3) - crhu_pkg::R0_W'(hg_s3);
	assign r0_d = (diff > crhu_pkg::R0_W'(crhu_pkg::HALF_Q)) ?
		diff - crhu_pkg::R0_W'(crhu_pkg::MOD_Q) : diff;

	always_ff @(posedge clk) begin
		h1_s1   <= sum7[24:7];
		a_s1    <= req.coeff;
		mode_s1 <= req.mode;

		prod_s2 <= prod_d;
		a_s2    <= a_s1;
		mode_s2 <= mode_s1;

		h_s3    <= h_d;
		hg_s3   <= hg_d;
		a_s3    <= a_s2;

		r0_s4   <= r0_d;
		r1_s4   <= h_s3;
	end

	assign rsp.r0 = r0_s4;
	assign rsp.r1 = r1_s4;

endmodule

// ----- rtl/core/coefficient_rounding_hint_unit.sv -----
// coefficient rounding hint unit: power2round, decompose, make hint, use hint
// an accepted request passes the valid stages v_s1 to v_s5 before its done strobe, one request per cycle
// busy is always low and the receiver cannot stall, so nothing is ever held back
// the rate is set by the five-stage pipeline, whose stage 2 is the reciprocal multiply
// arst_n clears the valid bits and the gamma2 mode register (mode 0: 44 parts)
// uses crhu_pkg, crhu_split and coefficient_rounding_hint_unit_assert.svh
`include "coefficient_rounding_hint_unit_assert.svh"

module coefficient_rounding_hint_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic                                cfg_wdata,
	// request side
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          op,
	input  logic signed [crhu_pkg::COEFF_W-1:0] coeff,
	input  logic [crhu_pkg::HIGH_W-1:0]         high_in,
	input  logic                                hint_in,
	// result side
	output logic                                done,
	output logic signed [crhu_pkg::LOW_W-1:0]   low_part,
	output logic [crhu_pkg::HIGH_W-1:0]         high_part,
	output logic                                hint_out
);

	// per-request side data that rides beside the decompose pipeline
	typedef struct packed {
		crhu_pkg::op_t                    op;
		logic                             hint;
		logic                             mode;
		logic                             mh;
		logic [crhu_pkg::LOW_W-1:0]       p2_lo;
		logic [crhu_pkg::HIGH_W-1:0]      p2_hi;
	} side_t;

	logic gamma2_mode_q;

	logic  v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t side_d, side_s1, side_s2, side_s3, side_s4;

	crhu_pkg::split_in_t  split_req;
	crhu_pkg::split_out_t split_rsp;

	// power2round: low part is the low 13 bits of the biased value, re-centered
	logic signed [crhu_pkg::COEFF_W:0]   sum13;
	logic signed [13:0]                  p2_lo;
	// make hint bounds
	logic signed [crhu_pkg::COEFF_W-1:0] g_lim;
	logic                                mh_d;

	// final stage
	logic signed [crhu_pkg::R0_W-1:0]    r0;
	logic signed [crhu_pkg::R1_W-1:0]    r1;
	logic [crhu_pkg::HIGH_W-1:0]         r1_ext;
	logic                                r0_pos;
	logic [3:0]                          uh_16;
	logic [crhu_pkg::HIGH_W-1:0]         uh_44;
	logic [crhu_pkg::HIGH_W-1:0]         uh_hi;

	logic signed [crhu_pkg::LOW_W-1:0]   low_d, low_part_s5;
	logic [crhu_pkg::HIGH_W-1:0]         high_d, high_part_s5;
	logic                                hint_d, hint_out_s5;

	// never busy: a new request can enter every cycle
	assign busy = 1'b0;

	// mode register; the user is to write it only while the pipeline is empty, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma2_mode_q <= 1'b0;
		end else if (cfg_we) begin
			gamma2_mode_q <= cfg_wdata;
		end
	end

	// power2round in front of stage 1
	assign sum13 = (crhu_pkg::COEFF_W + 1)'(coeff)
		+ (crhu_pkg::COEFF_W + 1)'(crhu_pkg::P2R_BIAS);
	assign p2_lo = $signed({1'b0, sum13[12:0]}) - 14'(crhu_pkg::P2R_BIAS);

	// make hint: low part outside [-gamma2, gamma2], edge case at -gamma2
	assign g_lim = gamma2_mode_q ? crhu_pkg::COEFF_W'(crhu_pkg::GAMMA2_32) :
		crhu_pkg::COEFF_W'(crhu_pkg::GAMMA2_88);
	assign mh_d = (coeff > g_lim) || (coeff < -g_lim) ||
		((coeff == -g_lim) && (high_in != '0));

	always_comb begin
		side_d       = '0;
		side_d.op    = crhu_pkg::op_t'(op);
		side_d.hint  = hint_in;
		side_d.mode  = gamma2_mode_q;
		side_d.mh    = mh_d;
		side_d.p2_lo = crhu_pkg::LOW_W'(p2_lo);
		side_d.p2_hi = sum13[22:13];
	end

	// decompose datapath, shared by decompose and use hint
	assign split_req.mode  = gamma2_mode_q;
	assign split_req.coeff = coeff;

	crhu_split u_split (
		.clk (clk),
		.req (split_req),
		.rsp (split_rsp)
	);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// side data, no reset needed
	always_ff @(posedge clk) begin
		side_s1 <= side_d;
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		side_s4 <= side_s3;
	end

	// use hint: step the high index up or down, wrapping per mode
	assign r0     = $signed(split_rsp.r0);
	assign r1     = $signed(split_rsp.r1);
	assign r1_ext = crhu_pkg::HIGH_W'(r1);
	assign r0_pos = r0 > crhu_pkg::R0_W'(0);
	assign uh_16  = r0_pos ? r1[3:0] + 4'd1 : r1[3:0] - 4'd1;

	always_comb begin
		if (r0_pos) begin
			uh_44 = (r1 == crhu_pkg::R1_W'(crhu_pkg::HI_MAX_88)) ? '0 : r1_ext + 10'd1;
		end else begin
			uh_44 = (r1 == '0) ? crhu_pkg::HIGH_W'(crhu_pkg::HI_MAX_88) : r1_ext - 10'd1;
		end
		if (!side_s4.hint) begin
			uh_hi = r1_ext;
		end else if (side_s4.mode) begin
			uh_hi = {6'b000000, uh_16};
		end else begin
			uh_hi = uh_44;
		end
	end

	// result select, unused fields zero
	always_comb begin
		low_d  = '0;
		high_d = '0;
		hint_d = 1'b0;
		unique case (side_s4.op)
			crhu_pkg::OP_POWER2ROUND: begin
				low_d  = side_s4.p2_lo;
				high_d = side_s4.p2_hi;
			end
			crhu_pkg::OP_DECOMPOSE: begin
				low_d  = r0[crhu_pkg::LOW_W-1:0];
				high_d = r1_ext;
			end
			crhu_pkg::OP_MAKE_HINT: begin
				hint_d = side_s4.mh;
			end
			crhu_pkg::OP_USE_HINT: begin
				high_d = uh_hi;
			end
			default: begin
				low_d  = '0;
			end
		endcase
	end

	// output register: results show for exactly one cycle with done
	always_ff @(posedge clk) begin
		low_part_s5  <= low_d;
		high_part_s5 <= high_d;
		hint_out_s5  <= hint_d;
	end

	assign done      = v_s5;
	assign low_part  = low_part_s5;
	assign high_part = high_part_s5;
	assign hint_out  = hint_out_s5;

	// every accepted request gives its done strobe, and no strobe comes without one
	`CRHU_ASSERT_DLY(a_latency, start && !busy, 5, done)
	`CRHU_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, 5))
	// a hint result carries no high or low part
	`CRHU_ASSERT_IMP(a_hint_alone, done && hint_out, low_part == '0 && high_part == '0)
	// use hint never reports a low part
	`CRHU_ASSERT_IMP(a_use_hint_low,
		done && $past(op == crhu_pkg::OP_USE_HINT, 5), low_part == '0)

endmodule
